/* hw/rtl/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros used by bwb_scale, the RTL datapath of the white balance block.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/bwb_pkg.sv */
// ---------------------------------------------------------------------------
// bwb_pkg
// Types, register indexes and mosaic site tables of the white balance block.
// ---------------------------------------------------------------------------
package bwb_pkg;

    localparam int PIX_W       = 16;
    localparam int COORD_W     = 13;
    localparam int GAIN_W      = 16;
    localparam int DEPTH_W     = 5;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    // Largest output depth and the floor applied to the depth register.
    localparam logic [DEPTH_W-1:0] PIXEL_BITS = 5'd16;
    localparam logic [DEPTH_W-1:0] DEPTH_MIN  = 5'd8;

    localparam logic [CFG_INDEX_W-1:0] REG_BAYER_ORDER = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_RGBIR_MODE  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_RED_GAIN    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_GREEN_GAIN  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_BLUE_GAIN   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_PIXEL_DEPTH = 3'd5;

    localparam logic [1:0] ORDER_BGGR = 2'd0;
    localparam logic [1:0] ORDER_GBRG = 2'd1;
    localparam logic [1:0] ORDER_GRBG = 2'd2;
    localparam logic [1:0] ORDER_RGGB = 2'd3;

    localparam logic [1:0]         RST_BAYER_ORDER = ORDER_RGGB;
    localparam logic [GAIN_W-1:0]  RST_GAIN        = 16'd1024;
    localparam logic [DEPTH_W-1:0] RST_PIXEL_DEPTH = 5'd12;

    typedef enum logic [2:0] {
        SITE_B,
        SITE_G,
        SITE_R,
        SITE_I,
        SITE_U
    } site_t;

    typedef struct packed {
        logic [1:0]         bayer_order;
        logic               rgbir_mode;
        logic [GAIN_W-1:0]  red_gain;
        logic [GAIN_W-1:0]  green_gain;
        logic [GAIN_W-1:0]  blue_gain;
        logic [DEPTH_W-1:0] pixel_depth;
    } cfg_t;

    // Plain 2x2 mosaic, indexed by order and {row[0], column[0]}.
    localparam site_t PLAIN_SITES [4][4] = '{
        '{SITE_B, SITE_G, SITE_G, SITE_R},
        '{SITE_G, SITE_B, SITE_R, SITE_G},
        '{SITE_G, SITE_R, SITE_B, SITE_G},
        '{SITE_R, SITE_G, SITE_G, SITE_B}
    };

    // RGBIR 4x4 mosaic. Odd rows are G I G I; even rows put R and B on even
    // columns, swapping every second row. Orders without a layout give SITE_U.
    function automatic site_t ir_site(input logic [1:0] ord, input logic [1:0] r,
                                      input logic [1:0] c);
        logic  first_red;
        site_t s;
        first_red = ((ord == ORDER_GBRG) ^ r[1]);
        if (ord != ORDER_GBRG && ord != ORDER_RGGB)
            s = SITE_U;
        else if (r[0])
            s = c[0] ? SITE_I : SITE_G;
        else if (c[0])
            s = SITE_G;
        else
            s = (first_red ^ c[1]) ? SITE_R : SITE_B;
        return s;
    endfunction

endpackage

/* hw/rtl/bwb_pix_if.sv */
// ---------------------------------------------------------------------------
// bwb_pix_in_if / bwb_pix_out_if
// Valid/ready pixel channels into and out of the white balance block.
// ---------------------------------------------------------------------------
interface bwb_pix_in_if;
    import bwb_pkg::*;

    logic               valid;
    logic               ready;
    logic [PIX_W-1:0]   pixel_in;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] column;

    modport source (output valid, output pixel_in, output row, output column,
                    input ready);
    modport sink (input valid, input pixel_in, input row, input column,
                  output ready);
endinterface

interface bwb_pix_out_if;
    import bwb_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_out;

    modport source (output valid, output pixel_out, input ready);
    modport sink (input valid, input pixel_out, output ready);
endinterface

/* hw/rtl/bwb_gain_sel.sv */
// ---------------------------------------------------------------------------
// bwb_gain_sel
// Finds the mosaic site of a pixel and selects the matching gain.
// ---------------------------------------------------------------------------
module bwb_gain_sel #(
    parameter int GAIN_FRAC_BITS = 10
) (
    input  bwb_pkg::cfg_t               cfg,
    input  logic [1:0]                  row_lsb,
    input  logic [1:0]                  col_lsb,
    output logic [bwb_pkg::GAIN_W-1:0]  gain
);
    import bwb_pkg::*;

    localparam logic [GAIN_W-1:0] UNITY_GAIN = GAIN_W'(1) << GAIN_FRAC_BITS;

    site_t site;

    always_comb
    begin
        if (cfg.rgbir_mode)
            site = ir_site(cfg.bayer_order, row_lsb, col_lsb);
        else
            site = PLAIN_SITES[cfg.bayer_order][{row_lsb[0], col_lsb[0]}];
    end

    // IR sites and orders without an RGBIR layout pass at unity gain.
    always_comb
    begin
        case (site)
            SITE_B:  gain = cfg.blue_gain;
            SITE_G:  gain = cfg.green_gain;
            SITE_R:  gain = cfg.red_gain;
            default: gain = UNITY_GAIN;
        endcase
    end
endmodule

/* hw/rtl/bwb_scale.sv */
// ---------------------------------------------------------------------------
// bwb_scale
// Multiply, round and clamp datapath with its output register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module bwb_scale #(
    parameter int GAIN_FRAC_BITS = 10
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [bwb_pkg::PIX_W-1:0]    in_pixel,
    input  logic [bwb_pkg::GAIN_W-1:0]   in_gain,
    input  logic [bwb_pkg::DEPTH_W-1:0]  pixel_depth,
    bwb_pix_out_if.source                pix_out
);
    import bwb_pkg::*;

    localparam int PROD_W = PIX_W + GAIN_W;
    localparam int SUM_W  = PROD_W + 1;
    localparam logic [SUM_W-1:0] HALF_LSB = SUM_W'(1) << (GAIN_FRAC_BITS - 1);

    logic               o_valid_reg;
    logic [PIX_W-1:0]   out_reg;
    logic [PIX_W-1:0]   out_next;
    logic [PROD_W-1:0]  product;
    logic [DEPTH_W-1:0] depth_eff;
    logic [PIX_W-1:0]   max_val;
    logic [SUM_W-1:0]   rounded;

    assign in_ready = !o_valid_reg || pix_out.ready;

    // Depth register is clamped into the supported range before use.
    always_comb
    begin
        if (pixel_depth < DEPTH_MIN)
            depth_eff = DEPTH_MIN;
        else if (pixel_depth > PIXEL_BITS)
            depth_eff = PIXEL_BITS;
        else
            depth_eff = pixel_depth;
    end

    assign max_val = PIX_W'(((PIX_W + 1)'(1) << depth_eff) - (PIX_W + 1)'(1));
    assign product = PROD_W'(in_pixel) * PROD_W'(in_gain);
    assign rounded = ({1'b0, product} + HALF_LSB) >> GAIN_FRAC_BITS;

    always_comb
    begin
        if (rounded > SUM_W'(max_val))
            out_next = max_val;
        else
            out_next = rounded[PIX_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            o_valid_reg <= 1'b0;
        else if (in_ready)
            o_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            out_reg <= out_next;
    end

    assign pix_out.valid     = o_valid_reg;
    assign pix_out.pixel_out = out_reg;

    `ASSERT_IMP(a_out_clamped, clk, rst_n, o_valid_reg, out_reg <= max_val,
                "result above the configured pixel depth")
    `ASSERT_NXT(a_out_held, clk, rst_n, o_valid_reg && !pix_out.ready,
                o_valid_reg && $stable(out_reg), "stalled result was lost")
    `ASSERT_IMP(a_ready_when_empty, clk, rst_n, !o_valid_reg, in_ready,
                "empty result stage refused a transfer")
endmodule

/* hw/rtl/bayer_white_balance_gain.sv */
// ---------------------------------------------------------------------------
// bayer_white_balance_gain
// Per-site white balance gain on a raw Bayer or RGBIR pixel stream.
// ---------------------------------------------------------------------------
//   channel   dir  handshake      payload
//   pix_in    in   valid/ready    pixel_in[15:0], row[12:0], column[12:0]
//   pix_out   out  valid/ready    pixel_out[15:0]
//   cfg       in   cfg_we         cfg_index[2:0], cfg_data[15:0]
//
// One pixel is taken every cycle unless a stall on pix_out holds the pipe. A
// pixel taken in sits in the input register with its gain until its result
// is loaded into the result register, which drives pix_out.
// The 16x16 multiply with rounding and clamp between the two registers sets
// the clock period.
// A stall on pix_out fills both registers and then drops pix_in.ready.
// Reset clears the stage valid bits and loads the register defaults.
// ---------------------------------------------------------------------------
module bayer_white_balance_gain #(
    parameter int GAIN_FRAC_BITS = 10
) (
    input  logic                              clk,
    input  logic                              rst_n,
    bwb_pix_in_if.sink                        pix_in,
    bwb_pix_out_if.source                     pix_out,
    input  logic                              cfg_we,
    input  logic [bwb_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [bwb_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import bwb_pkg::*;

    cfg_t              cfg_reg;
    logic              s1_valid_reg;
    logic [PIX_W-1:0]  s1_pixel_reg;
    logic [GAIN_W-1:0] s1_gain_reg;
    logic [GAIN_W-1:0] gain_sel;
    logic              scale_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.bayer_order <= RST_BAYER_ORDER;
            cfg_reg.rgbir_mode  <= 1'b0;
            cfg_reg.red_gain    <= RST_GAIN;
            cfg_reg.green_gain  <= RST_GAIN;
            cfg_reg.blue_gain   <= RST_GAIN;
            cfg_reg.pixel_depth <= RST_PIXEL_DEPTH;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_BAYER_ORDER: cfg_reg.bayer_order <= cfg_data[1:0];
                REG_RGBIR_MODE:  cfg_reg.rgbir_mode  <= cfg_data[0];
                REG_RED_GAIN:    cfg_reg.red_gain    <= cfg_data;
                REG_GREEN_GAIN:  cfg_reg.green_gain  <= cfg_data;
                REG_BLUE_GAIN:   cfg_reg.blue_gain   <= cfg_data;
                REG_PIXEL_DEPTH: cfg_reg.pixel_depth <= cfg_data[DEPTH_W-1:0];
                default:         ;
            endcase
        end
    end

    bwb_gain_sel #(
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_gain_sel (
        .cfg     (cfg_reg),
        .row_lsb (pix_in.row[1:0]),
        .col_lsb (pix_in.column[1:0]),
        .gain    (gain_sel)
    );

    // Input stage holds the pixel with its gain already chosen.
    assign pix_in.ready = !s1_valid_reg || scale_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (pix_in.ready)
            s1_valid_reg <= pix_in.valid;
    end

    always_ff @(posedge clk)
    begin
        if (pix_in.valid && pix_in.ready)
        begin
            s1_pixel_reg <= pix_in.pixel_in;
            s1_gain_reg  <= gain_sel;
        end
    end

    bwb_scale #(
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_scale (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s1_valid_reg),
        .in_ready    (scale_ready),
        .in_pixel    (s1_pixel_reg),
        .in_gain     (s1_gain_reg),
        .pixel_depth (cfg_reg.pixel_depth),
        .pix_out     (pix_out)
    );
endmodule

/* sim/tb_top.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Bayer/RGBIR white balance gain block. Pixels
// go in over a valid/ready channel with random gaps while the output side
// stalls at random. Each input transfer is run through a local site and gain
// predictor, and every output transfer is checked in order against it. The
// register set is rewritten between batches, only while the pipe is empty.
// ---------------------------------------------------------------------------
module tb_top;
    import bwb_pkg::*;

    localparam int GAIN_FRAC = 10;
    localparam int LATENCY   = 2;
    localparam int RUN_LIMIT = 200000;
    localparam int BATCHES   = 21;
    localparam int BATCH_LEN = 50;

    // Indexes that decode to no register; writes there must be ignored.
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 3'd7;

    typedef struct {
        logic [PIX_W-1:0]   pixel;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] column;
        logic [PIX_W-1:0]   value;
    } pixel_expect_t;

    class gain_scoreboard;
        cfg_t          regs;
        pixel_expect_t expected_pixels[$];
        int            errors;
        int            checked;
        int            site_hits[5];

        function new();
            regs.bayer_order = RST_BAYER_ORDER;
            regs.rgbir_mode  = 1'b0;
            regs.red_gain    = RST_GAIN;
            regs.green_gain  = RST_GAIN;
            regs.blue_gain   = RST_GAIN;
            regs.pixel_depth = RST_PIXEL_DEPTH;
        endfunction

        function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_BAYER_ORDER: regs.bayer_order = data[1:0];
                REG_RGBIR_MODE:  regs.rgbir_mode  = data[0];
                REG_RED_GAIN:    regs.red_gain    = data;
                REG_GREEN_GAIN:  regs.green_gain  = data;
                REG_BLUE_GAIN:   regs.blue_gain   = data;
                REG_PIXEL_DEPTH: regs.pixel_depth = data[DEPTH_W-1:0];
                default: ;
            endcase
        endfunction

        function site_t site_of(logic [COORD_W-1:0] row, logic [COORD_W-1:0] column);
            logic [1:0] r;
            logic [1:0] c;
            logic [1:0] pos;
            site_t      s;
            r = row[1:0];
            c = column[1:0];
            if (regs.rgbir_mode)
            begin
                if (regs.bayer_order != ORDER_GBRG && regs.bayer_order != ORDER_RGGB)
                    s = SITE_U;
                else if (r[0])
                    s = c[0] ? SITE_I : SITE_G;
                else if (c[0])
                    s = SITE_G;
                // GBRG puts red first at the origin, RGGB blue; row 2 and
                // column 2 each swap red and blue.
                else if ((regs.bayer_order == ORDER_GBRG) ^ r[1] ^ c[1])
                    s = SITE_R;
                else
                    s = SITE_B;
            end
            else
            begin
                pos = {r[0], c[0]};
                case (regs.bayer_order)
                    ORDER_BGGR: s = (pos == 2'd0) ? SITE_B : ((pos == 2'd3) ? SITE_R : SITE_G);
                    ORDER_GBRG: s = (pos == 2'd1) ? SITE_B : ((pos == 2'd2) ? SITE_R : SITE_G);
                    ORDER_GRBG: s = (pos == 2'd2) ? SITE_B : ((pos == 2'd1) ? SITE_R : SITE_G);
                    default:    s = (pos == 2'd0) ? SITE_R : ((pos == 2'd3) ? SITE_B : SITE_G);
                endcase
            end
            return s;
        endfunction

        function logic [PIX_W-1:0] gained_pixel(logic [PIX_W-1:0] pixel, site_t s);
            logic [GAIN_W-1:0]  gain;
            logic [DEPTH_W-1:0] depth;
            logic [32:0]        prod;
            logic [32:0]        ceiling;
            case (s)
                SITE_R:  gain = regs.red_gain;
                SITE_G:  gain = regs.green_gain;
                SITE_B:  gain = regs.blue_gain;
                default: gain = GAIN_W'(1 << GAIN_FRAC);
            endcase
            depth = regs.pixel_depth;
            if (depth < DEPTH_MIN)
                depth = DEPTH_MIN;
            if (depth > PIXEL_BITS)
                depth = PIXEL_BITS;
            ceiling = (33'd1 << depth) - 33'd1;
            prod = 33'(pixel) * 33'(gain) + (33'd1 << (GAIN_FRAC - 1));
            prod = prod >> GAIN_FRAC;
            if (prod > ceiling)
                prod = ceiling;
            return prod[PIX_W-1:0];
        endfunction

        function void note_pixel(logic [PIX_W-1:0] pixel, logic [COORD_W-1:0] row,
                                 logic [COORD_W-1:0] column);
            pixel_expect_t e;
            site_t         s;
            s = site_of(row, column);
            site_hits[int'(s)]++;
            e.pixel  = pixel;
            e.row    = row;
            e.column = column;
            e.value  = gained_pixel(pixel, s);
            expected_pixels.push_back(e);
        endfunction

        task report(string what);
            if (errors < 25)
                $display("mismatch at %0t: %s", $realtime, what);
            errors++;
        endtask

        task check_pixel(logic [PIX_W-1:0] value);
            pixel_expect_t e;
            if (expected_pixels.size() == 0)
            begin
                report($sformatf("pixel_out %0d with no pixel in flight", value));
            end
            else
            begin
                e = expected_pixels.pop_front();
                checked++;
                if (value !== e.value)
                    report($sformatf("pixel_out %0d, want %0d (pixel %0d row %0d col %0d)",
                                     value, e.value, e.pixel, e.row, e.column));
            end
        endtask

        function int pending();
            return expected_pixels.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    bwb_pix_in_if  pix_in_ch ();
    bwb_pix_out_if pix_out_ch ();

    bayer_white_balance_gain #(
        .GAIN_FRAC_BITS(GAIN_FRAC)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .pix_in   (pix_in_ch),
        .pix_out  (pix_out_ch),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    gain_scoreboard sb = new();
    int send_idle_pct;
    int recv_idle_pct;
    int settings_used;
    int pixels_sent;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Output side: ready is held low in reset and redrawn every cycle after.
    always @(posedge clk)
    begin
        if (!rst_n)
            pix_out_ch.ready <= 1'b0;
        else
            pix_out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Both channels are sampled at the edge, before any driver update lands.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pix_in_ch.valid && pix_in_ch.ready)
                sb.note_pixel(pix_in_ch.pixel_in, pix_in_ch.row, pix_in_ch.column);
            if (pix_out_ch.valid && pix_out_ch.ready)
                sb.check_pixel(pix_out_ch.pixel_out);
        end
    end

    initial
    begin
        repeat (RUN_LIMIT) @(posedge clk);
        $display("run stopped at the cycle limit with %0d pixels in flight", sb.pending());
        $display("status: fail");
        $finish;
    end

    function automatic logic [GAIN_W-1:0] pick_gain();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            2:       return RST_GAIN;
            3, 4:    return GAIN_W'($urandom_range(2047));
            default: return GAIN_W'($urandom);
        endcase
    endfunction

    // Leaves valid high so that the next pixel can follow without a gap.
    task send_pixel(logic [PIX_W-1:0] pixel, logic [COORD_W-1:0] row,
                    logic [COORD_W-1:0] column);
        while ($urandom_range(99) < send_idle_pct)
        begin
            pix_in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        pix_in_ch.valid    <= 1'b1;
        pix_in_ch.pixel_in <= pixel;
        pix_in_ch.row      <= row;
        pix_in_ch.column   <= column;
        @(posedge clk);
        while (!pix_in_ch.ready)
            @(posedge clk);
        pixels_sent++;
    endtask

    // Drops valid and waits for the pipe to drain. The first edge lets the
    // monitor note the last transfer before the count is looked at.
    task settle();
        pix_in_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (LATENCY + 2) @(posedge clk);
    endtask

    task write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        sb.set_reg(idx, data);
    endtask

    // Unused upper data bits carry junk; the narrow registers must drop them.
    task program_config(cfg_t c);
        logic [CFG_DATA_W-1:0] junk;
        junk = CFG_DATA_W'($urandom);
        write_reg(REG_BAYER_ORDER, {junk[15:2], c.bayer_order});
        write_reg(REG_RGBIR_MODE, {junk[14:0], c.rgbir_mode});
        write_reg(REG_RED_GAIN, c.red_gain);
        write_reg(REG_GREEN_GAIN, c.green_gain);
        write_reg(REG_BLUE_GAIN, c.blue_gain);
        write_reg(REG_PIXEL_DEPTH, {junk[10:0], c.pixel_depth});
        write_reg(junk[0] ? REG_SPARE_HI : REG_SPARE_LO, ~junk);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    initial
    begin
        cfg_t                  c;
        logic [PIX_W-1:0]      pixel;
        rst_n              <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_index          <= '0;
        cfg_data           <= '0;
        pix_in_ch.valid    <= 1'b0;
        pix_in_ch.pixel_in <= '0;
        pix_in_ch.row      <= '0;
        pix_in_ch.column   <= '0;
        send_idle_pct = 10;
        recv_idle_pct = 77;
        settings_used = 1;
        pixels_sent   = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Register defaults: RGGB, unity gains, 12-bit clamp.
        send_pixel(16'hFFFF, 13'd0, 13'd0);
        send_pixel(16'd0, 13'd0, 13'd1);
        send_pixel(16'd4095, 13'd1, 13'd0);
        send_pixel(16'd1, 13'd1, 13'd1);
        send_pixel(16'd1, 13'h1FFF, 13'h1FFF);
        send_pixel(16'd512, 13'h1FFE, 13'h1FFD);
        settle();

        // Full-scale, zero and minimum gains; rounding at the half step.
        program_config('{bayer_order: ORDER_BGGR, rgbir_mode: 1'b0, red_gain: 16'hFFFF,
                         green_gain: 16'd0, blue_gain: 16'd1, pixel_depth: 5'd16});
        send_pixel(16'hFFFF, 13'd0, 13'd0);
        send_pixel(16'hFFFF, 13'd1, 13'd1);
        send_pixel(16'hFFFF, 13'd0, 13'd1);
        send_pixel(16'd511, 13'd0, 13'd0);
        send_pixel(16'd512, 13'd0, 13'd0);
        settle();

        // RGBIR with a depth below the floor, IR sites at unity.
        program_config('{bayer_order: ORDER_RGGB, rgbir_mode: 1'b1, red_gain: 16'd2048,
                         green_gain: 16'd512, blue_gain: 16'd3072, pixel_depth: 5'd3});
        send_pixel(16'd100, 13'd0, 13'd0);
        send_pixel(16'd100, 13'd0, 13'd2);
        send_pixel(16'd100, 13'd2, 13'd0);
        send_pixel(16'd100, 13'd1, 13'd1);
        send_pixel(16'd100, 13'd1, 13'd0);
        send_pixel(16'd300, 13'd3, 13'd3);
        send_pixel(16'd100, 13'd2, 13'd2);
        settle();

        // Other RGBIR layout, depth above the ceiling.
        program_config('{bayer_order: ORDER_GBRG, rgbir_mode: 1'b1, red_gain: 16'd3000,
                         green_gain: 16'd700, blue_gain: 16'd100, pixel_depth: 5'd31});
        send_pixel(16'd40000, 13'd0, 13'd0);
        send_pixel(16'd40000, 13'd2, 13'd0);
        send_pixel(16'd40000, 13'd1, 13'd3);
        settle();

        // RGBIR order with no layout passes everything at unity.
        program_config('{bayer_order: ORDER_GRBG, rgbir_mode: 1'b1, red_gain: 16'd5000,
                         green_gain: 16'd5000, blue_gain: 16'd5000, pixel_depth: 5'd20});
        send_pixel(16'hFFFF, 13'd0, 13'd0);
        send_pixel(16'd1000, 13'd1, 13'd1);
        settle();

        program_config('{bayer_order: ORDER_GBRG, rgbir_mode: 1'b0, red_gain: 16'd1500,
                         green_gain: 16'd900, blue_gain: 16'd2500, pixel_depth: 5'd8});
        send_pixel(16'd300, 13'd0, 13'd1);
        send_pixel(16'd300, 13'd1, 13'd0);
        settle();

        // Random batches, each under a fresh register setting. The idle
        // profile moves from slow output, to slow input, to no gaps at all.
        for (int b = 0; b < BATCHES; b++)
        begin
            if (b < BATCHES / 3)
            begin
                send_idle_pct = 10;
                recv_idle_pct = 77;
            end
            else if (b < 2 * BATCHES / 3)
            begin
                send_idle_pct = 77;
                recv_idle_pct = 10;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            c.bayer_order = 2'($urandom);
            c.rgbir_mode  = 1'($urandom);
            c.red_gain    = pick_gain();
            c.green_gain  = pick_gain();
            c.blue_gain   = pick_gain();
            if ($urandom_range(4) == 0)
                c.pixel_depth = DEPTH_W'($urandom);
            else
                c.pixel_depth = DEPTH_W'($urandom_range(16, 8));
            program_config(c);
            for (int i = 0; i < BATCH_LEN; i++)
            begin
                case ($urandom_range(9))
                    0:       pixel = '1;
                    1:       pixel = '0;
                    2, 3:    pixel = PIX_W'($urandom_range(4095));
                    default: pixel = PIX_W'($urandom);
                endcase
                send_pixel(pixel, COORD_W'($urandom), COORD_W'($urandom));
            end
            settle();
        end

        repeat (4 * LATENCY) @(posedge clk);
        if (sb.pending() != 0)
            sb.report($sformatf("%0d expected pixels never came out", sb.pending()));
        $display("covered %0d pixels under %0d register settings; %0d results checked",
                 pixels_sent, settings_used, sb.checked);
        $display("site mix: red %0d, green %0d, blue %0d, ir %0d, no-layout %0d",
                 sb.site_hits[int'(SITE_R)], sb.site_hits[int'(SITE_G)],
                 sb.site_hits[int'(SITE_B)], sb.site_hits[int'(SITE_I)],
                 sb.site_hits[int'(SITE_U)]);
        if (sb.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
